// File: design/nsd_pkg.sv
// shared types, widths and codes for the nearest segment direction block
package nsd_pkg;

  localparam int CW         = 32;        // coordinate width, Q16.16
  localparam int DW         = CW + 1;    // differences of two coordinates
  localparam int OW         = CW + 2;    // projected offset
  localparam int EW         = CW + 3;    // residual w - o
  localparam int MW         = EW;        // multiplier operand width
  localparam int PW         = 2 * MW;    // product width
  localparam int AW         = PW + 2;    // accumulator and divider width
  localparam int FW         = 32;        // fraction bits of t
  localparam int QW         = FW + 1;    // quotient width
  localparam int SW         = QW + 1;    // square root working width
  localparam int DISTW      = 64;
  localparam int DIRW       = 16;
  localparam int CNTW       = 6;
  localparam int DIV_STEPS  = QW;
  localparam int SQRT_STEPS = (QW + 1) / 2;
  localparam logic [CNTW-1:0] MUL_LAST  = CNTW'(3);
  localparam logic [CNTW-1:0] DIV_LAST  = CNTW'(DIV_STEPS - 1);
  localparam logic [CNTW-1:0] SQRT_LAST = CNTW'(SQRT_STEPS - 1);
  localparam logic [1:0]      COMP_LAST = 2'd2;
  localparam logic [DIRW-1:0] DIR_MAX   = 16'd32767;

  typedef struct packed {
    logic                 kind;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;
    logic                 last;
  } in_item_t;

  typedef struct packed {
    logic signed [DIRW-1:0] dir_x;
    logic signed [DIRW-1:0] dir_y;
    logic signed [DIRW-1:0] dir_z;
    logic                   degenerate;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_DOT, OP_LEN, OP_PROJ, OP_DIST, OP_NORM, OP_NUM
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DOT, ST_LEN, ST_DECIDE, ST_DIV, ST_PROJ, ST_DIST, ST_UPDATE,
    ST_NORM, ST_SQM, ST_SQA, ST_CDIV, ST_SQI, ST_SQRT, ST_STORE, ST_OUT
  } state_t;

  typedef struct packed {
    logic       load_point;
    logic       load_seg;
    op_t        mul_sel;
    logic [1:0] mul_k;
    op_t        acc_sel;
    logic [1:0] acc_k;
    logic       decide;
    logic       div_step;
    logic       div_first;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       store_dir;
    logic [1:0] dir_k;
    logic       update;
    logic       last;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic span_zero;
  } sts_t;

endpackage

// File: design/nsd_if.sv
// valid/ready channel interfaces for input and result items
interface nsd_in_if;
  import nsd_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nsd_out_if;
  import nsd_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/nsd_datapath.sv
// datapath: shared multiplier, accumulators, divider, square root and best segment store
module nsd_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  nsd_pkg::in_item_t  in_data,
  input  nsd_pkg::cmd_t      cmd,
  output nsd_pkg::sts_t      sts,
  output nsd_pkg::out_item_t out_data
);
  import nsd_pkg::*;

  logic signed [CW-1:0]   qp_r [3];
  logic [DISTW-1:0]       best_dist_r;
  logic signed [DW-1:0]   best_span_r [3];
  logic                   have_best_r;

  logic signed [DW-1:0]   d_r [3];
  logic signed [DW-1:0]   w_r [3];
  logic signed [DW-1:0]   cand_r [3];
  logic signed [OW-1:0]   o_r [3];
  logic signed [PW-1:0]   prod_r;
  logic [AW-1:0]          acc_r;
  logic [AW-1:0]          len2_r;
  logic [AW-1:0]          rem_r;
  logic [AW-1:0]          div_r;
  logic [QW-1:0]          quo_r;
  logic [SW-1:0]          num_r;
  logic [SW-1:0]          res_r;
  logic [SW-1:0]          bit_r;
  logic signed [DIRW-1:0] stage_r [3];
  out_item_t              out_r;

  logic signed [DW-1:0]   s_ext [3];
  logic signed [DW-1:0]   e_ext [3];
  logic [DW-1:0]          dmag [3];
  logic [DW-1:0]          smag [3];
  logic signed [EW-1:0]   res_e [3];
  logic signed [MW-1:0]   op_a;
  logic signed [MW-1:0]   op_b;
  logic [PW-1:0]          psum;
  logic signed [OW-1:0]   p_off;
  logic                   dot_le0;
  logic                   dot_ge;
  logic [AW-1:0]          tr;
  logic                   tr_ge;
  logic [SW-1:0]          rb;
  logic [SW-1:0]          qv;
  logic [DIRW-1:0]        qc;
  logic [DISTW-1:0]       dist_sat;
  logic                   better;

  always_comb begin
    s_ext[0] = DW'(in_data.start_x);
    s_ext[1] = DW'(in_data.start_y);
    s_ext[2] = DW'(in_data.start_z);
    e_ext[0] = DW'(in_data.end_x);
    e_ext[1] = DW'(in_data.end_y);
    e_ext[2] = DW'(in_data.end_z);
    for (int k = 0; k < 3; k++) begin
      dmag[k]  = d_r[k][DW-1] ? DW'(-d_r[k]) : DW'(d_r[k]);
      smag[k]  = best_span_r[k][DW-1] ? DW'(-best_span_r[k]) : DW'(best_span_r[k]);
      res_e[k] = EW'(w_r[k]) - EW'(o_r[k]);
    end
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      OP_DOT: begin
        op_a = MW'(d_r[cmd.mul_k]);
        op_b = MW'(w_r[cmd.mul_k]);
      end
      OP_LEN: begin
        op_a = MW'(d_r[cmd.mul_k]);
        op_b = MW'(d_r[cmd.mul_k]);
      end
      OP_PROJ: begin
        op_a = MW'(dmag[cmd.mul_k]);
        op_b = MW'(quo_r[FW-1:0]);
      end
      OP_DIST: begin
        op_a = res_e[cmd.mul_k];
        op_b = res_e[cmd.mul_k];
      end
      OP_NORM: begin
        op_a = MW'(smag[cmd.mul_k]);
        op_b = MW'(smag[cmd.mul_k]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // round the projected offset to nearest
  assign psum  = $unsigned(prod_r) + (PW'(1) << (FW - 1));
  assign p_off = OW'(psum[PW-1:FW]);

  assign dot_le0 = acc_r[AW-1] || (acc_r == '0);
  assign dot_ge  = acc_r >= len2_r;

  assign sts.need_div  = (len2_r != '0) && !dot_le0 && !dot_ge;
  assign sts.span_zero = (smag[0] == '0) && (smag[1] == '0) && (smag[2] == '0);

  assign tr    = cmd.div_first ? rem_r : (rem_r << 1);
  assign tr_ge = tr >= div_r;

  assign rb = res_r + bit_r;
  assign qv = (res_r + SW'(1)) >> 1;
  assign qc = (qv > SW'(DIR_MAX)) ? DIR_MAX : qv[DIRW-1:0];

  assign dist_sat = (acc_r[AW-1:DISTW] != '0) ? '1 : acc_r[DISTW-1:0];
  assign better   = !have_best_r || (dist_sat < best_dist_r);

  // query point and kept segment
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        qp_r[k]        <= '0;
        best_span_r[k] <= '0;
      end
      best_dist_r <= '1;
      have_best_r <= 1'b0;
    end else begin
      if (cmd.load_point) begin
        qp_r[0]     <= in_data.start_x;
        qp_r[1]     <= in_data.start_y;
        qp_r[2]     <= in_data.start_z;
        best_dist_r <= '1;
        have_best_r <= 1'b0;
      end
      if (cmd.update) begin
        if (better) begin
          best_span_r <= cand_r;
        end
        // a finished query starts the next one empty
        if (cmd.last) begin
          best_dist_r <= '1;
          have_best_r <= 1'b0;
        end else if (better) begin
          best_dist_r <= dist_sat;
          have_best_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;

    if (cmd.load_seg) begin
      for (int k = 0; k < 3; k++) begin
        d_r[k]    <= e_ext[k] - s_ext[k];
        w_r[k]    <= DW'(qp_r[k]) - s_ext[k];
        cand_r[k] <= s_ext[k] - e_ext[k];
      end
      acc_r  <= '0;
      len2_r <= '0;
    end

    if (cmd.acc_sel inside {OP_DOT, OP_DIST, OP_NORM}) begin
      acc_r <= acc_r + AW'(prod_r);
    end
    if (cmd.acc_sel == OP_LEN) begin
      len2_r <= len2_r + AW'(prod_r);
    end
    if (cmd.acc_sel == OP_PROJ) begin
      o_r[cmd.acc_k] <= d_r[cmd.acc_k][DW-1] ? -p_off : p_off;
    end
    if (cmd.acc_sel == OP_NUM) begin
      rem_r <= AW'($unsigned(prod_r));
      div_r <= acc_r;
      quo_r <= '0;
    end

    if (cmd.decide) begin
      for (int k = 0; k < 3; k++) begin
        o_r[k] <= ((len2_r != '0) && !dot_le0 && dot_ge) ? OW'(d_r[k]) : '0;
      end
      rem_r <= acc_r;
      div_r <= len2_r;
      quo_r <= '0;
      acc_r <= '0;
    end

    if (cmd.div_step) begin
      rem_r <= tr_ge ? (tr - div_r) : tr;
      quo_r <= {quo_r[QW-2:0], tr_ge};
    end

    if (cmd.update) begin
      acc_r <= '0;
    end

    if (cmd.sqrt_init) begin
      num_r <= SW'(quo_r);
      res_r <= '0;
      bit_r <= SW'(1) << (SW - 2);
    end
    if (cmd.sqrt_step) begin
      if (num_r >= rb) begin
        num_r <= num_r - rb;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end

    if (cmd.store_dir) begin
      stage_r[cmd.dir_k] <= best_span_r[cmd.dir_k][DW-1] ? -$signed(qc) : $signed(qc);
    end

    if (cmd.out_load) begin
      out_r.dir_x      <= sts.span_zero ? '0 : stage_r[0];
      out_r.dir_y      <= sts.span_zero ? '0 : stage_r[1];
      out_r.dir_z      <= sts.span_zero ? '0 : stage_r[2];
      out_r.degenerate <= sts.span_zero;
    end
  end

  assign out_data = out_r;

endmodule

// File: design/nsd_ctrl.sv
// controller: sequences multiply, divide and square root steps for segment items
module nsd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_kind,
  input  logic          in_last,
  input  logic          out_ready,
  output logic          out_valid,
  input  nsd_pkg::sts_t sts,
  output nsd_pkg::cmd_t cmd
);
  import nsd_pkg::*;

  state_t          state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [1:0]      comp_r, comp_nxt;
  logic            last_r, last_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            out_load;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      comp_r      <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      comp_r      <= comp_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r + CNTW'(1);
    comp_nxt      = comp_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept && in_kind) begin
          last_nxt  = in_last;
          state_nxt = ST_DOT;
        end
      end
      ST_DOT: begin
        if (cnt_r == MUL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        if (cnt_r == MUL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cnt_nxt   = '0;
        state_nxt = sts.need_div ? ST_DIV : ST_DIST;
      end
      ST_DIV: begin
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_PROJ;
        end
      end
      ST_PROJ: begin
        if (cnt_r == MUL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIST;
        end
      end
      ST_DIST: begin
        if (cnt_r == MUL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cnt_nxt   = '0;
        state_nxt = last_r ? ST_NORM : ST_IDLE;
      end
      ST_NORM: begin
        if (cnt_r == MUL_LAST) begin
          cnt_nxt   = '0;
          comp_nxt  = '0;
          state_nxt = sts.span_zero ? ST_OUT : ST_SQM;
        end
      end
      ST_SQM: begin
        state_nxt = ST_SQA;
      end
      ST_SQA: begin
        cnt_nxt   = '0;
        state_nxt = ST_CDIV;
      end
      ST_CDIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_SQI;
        end
      end
      ST_SQI: begin
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt_r == SQRT_LAST) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        if (comp_r == COMP_LAST) begin
          state_nxt = ST_OUT;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = ST_SQM;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load_point = accept && !in_kind;
        cmd.load_seg   = accept && in_kind;
      end
      ST_DOT: begin
        cmd.mul_sel = (cnt_r < MUL_LAST) ? OP_DOT : OP_NONE;
        cmd.mul_k   = cnt_r[1:0];
        cmd.acc_sel = (cnt_r != '0) ? OP_DOT : OP_NONE;
        cmd.acc_k   = cnt_r[1:0] - 2'd1;
      end
      ST_LEN: begin
        cmd.mul_sel = (cnt_r < MUL_LAST) ? OP_LEN : OP_NONE;
        cmd.mul_k   = cnt_r[1:0];
        cmd.acc_sel = (cnt_r != '0) ? OP_LEN : OP_NONE;
        cmd.acc_k   = cnt_r[1:0] - 2'd1;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
      end
      ST_DIV, ST_CDIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == '0);
      end
      ST_PROJ: begin
        cmd.mul_sel = (cnt_r < MUL_LAST) ? OP_PROJ : OP_NONE;
        cmd.mul_k   = cnt_r[1:0];
        cmd.acc_sel = (cnt_r != '0) ? OP_PROJ : OP_NONE;
        cmd.acc_k   = cnt_r[1:0] - 2'd1;
      end
      ST_DIST: begin
        cmd.mul_sel = (cnt_r < MUL_LAST) ? OP_DIST : OP_NONE;
        cmd.mul_k   = cnt_r[1:0];
        cmd.acc_sel = (cnt_r != '0) ? OP_DIST : OP_NONE;
        cmd.acc_k   = cnt_r[1:0] - 2'd1;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        cmd.last   = last_r;
      end
      ST_NORM: begin
        cmd.mul_sel = (cnt_r < MUL_LAST) ? OP_NORM : OP_NONE;
        cmd.mul_k   = cnt_r[1:0];
        cmd.acc_sel = (cnt_r != '0) ? OP_NORM : OP_NONE;
        cmd.acc_k   = cnt_r[1:0] - 2'd1;
      end
      ST_SQM: begin
        cmd.mul_sel = OP_NORM;
        cmd.mul_k   = comp_r;
      end
      ST_SQA: begin
        cmd.acc_sel = OP_NUM;
      end
      ST_SQI: begin
        cmd.sqrt_init = 1'b1;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
      end
      ST_STORE: begin
        cmd.store_dir = 1'b1;
        cmd.dir_k     = comp_r;
      end
      ST_OUT: begin
        cmd.out_load = out_load;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: design/nearest_segment_direction_top.sv
// top level: nearest segment direction from point and segment items
// a segment takes longer when its projection needs the 33-step divider
// a last segment adds, unless its kept span is zero, per axis one 33-step divide and a 17-step root
// throughput is one item at a time, set by the shared multiplier and the divider
// the result sits in an output register, so the next item is taken while it waits
// synchronous active-low reset: query point zero, no kept segment, no result pending
module nearest_segment_direction_top (
  input logic    clk,
  input logic    rst_n,
  nsd_in_if.sink    in_ch,
  nsd_out_if.source out_ch
);
  import nsd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_kind   (in_ch.data.kind),
    .in_last   (in_ch.data.last),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  nsd_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_ch.data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_ch.data)
  );

endmodule

// File: test/tb_top.sv
// testbench for the nearest segment direction block: directed table, then random queries
`timescale 1ns / 1ps

module tb_top;
  import nsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int HOLD_CYCLES    = 3000;
  localparam int ITEMS_PER_PHASE = 400;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nsd_in_if  in_ch ();
  nsd_out_if out_ch ();

  nearest_segment_direction_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // predictor state
  longint          query_pt [3];
  longint          kept_span [3];
  longint unsigned kept_dist;
  bit              kept_valid;

  out_item_t expected_dirs [$];
  int        errors;
  int        idle_pct;
  int        stall_pct;
  int        hold_ask;
  int        hold_seen;
  int        hold_left;
  int        quiet_cycles;

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint unsigned magn(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic out_item_t unit_direction();
    longint unsigned m [3];
    logic [127:0]    n2;
    logic [127:0]    tgt;
    logic [127:0]    odd;
    int              lo;
    int              hi;
    int              q;
    out_item_t       r;
    r = '0;
    for (int k = 0; k < 3; k++) m[k] = magn(kept_span[k]);
    if ((m[0] | m[1] | m[2]) == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    while (m[0] >= (64'd1 << 40) || m[1] >= (64'd1 << 40) || m[2] >= (64'd1 << 40)) begin
      for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
    end
    n2 = '0;
    for (int k = 0; k < 3; k++) n2 += 128'(m[k]) * 128'(m[k]);
    for (int k = 0; k < 3; k++) begin
      tgt = (128'(m[k]) * 128'(m[k])) << 32;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        q = (lo + hi + 1) / 2;
        odd = 128'(2 * q - 1);
        if (n2 * odd * odd <= tgt) lo = q;
        else hi = q - 1;
      end
      if (lo > 32767) lo = 32767;
      if (kept_span[k] < 0) lo = -lo;
      case (k)
        0: r.dir_x = DIRW'(lo);
        1: r.dir_y = DIRW'(lo);
        default: r.dir_z = DIRW'(lo);
      endcase
    end
    return r;
  endfunction

  // advances the predictor by one accepted item, returns 1 with the result if one is due
  function automatic bit nearest_step(in_item_t it, output out_item_t r);
    longint                s [3];
    longint                e [3];
    longint                d [3];
    longint                w [3];
    longint                o [3];
    logic signed [127:0]   dot;
    logic signed [127:0]   len2;
    logic [191:0]          t;
    logic [127:0]          p;
    logic [127:0]          dsum;
    logic [127:0]          mm;
    longint unsigned       dsat;
    r = '0;
    s[0] = it.start_x; s[1] = it.start_y; s[2] = it.start_z;
    e[0] = it.end_x;   e[1] = it.end_y;   e[2] = it.end_z;
    if (!it.kind) begin
      query_pt = s;
      kept_dist = '1;
      kept_valid = 1'b0;
      return 1'b0;
    end
    dot = '0;
    len2 = '0;
    for (int k = 0; k < 3; k++) begin
      d[k] = e[k] - s[k];
      w[k] = query_pt[k] - s[k];
      dot += d[k] * w[k];
      len2 += d[k] * d[k];
      o[k] = 0;
    end
    if (len2 == 0 || dot <= 0) begin
      // closest point is the start
    end else if (dot >= len2) begin
      o = d;
    end else begin
      t = (192'(dot) << 32) / 192'(len2);
      for (int k = 0; k < 3; k++) begin
        p = (128'(magn(d[k])) * t[127:0] + (128'd1 << 31)) >> 32;
        o[k] = (d[k] < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
      end
    end
    dsum = '0;
    for (int k = 0; k < 3; k++) begin
      mm = 128'(magn(w[k] - o[k]));
      dsum += mm * mm;
    end
    dsat = (dsum[127:64] != 0) ? '1 : dsum[63:0];
    if (!kept_valid || dsat < kept_dist) begin
      kept_dist = dsat;
      for (int k = 0; k < 3; k++) kept_span[k] = s[k] - e[k];
      kept_valid = 1'b1;
    end
    if (!it.last) return 1'b0;
    r = unit_direction();
    kept_dist = '1;
    kept_valid = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t r;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    if (nearest_step(it, r)) expected_dirs.push_back(typed ? want : r);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_dirs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom_range(32 << 16) - (16 << 16);
      5, 6:          return $urandom;
      7: begin
        case ($urandom_range(4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default:       return $urandom_range(255) - 128;
    endcase
  endfunction

  function automatic in_item_t make_item(bit kind, bit last, bit flat);
    in_item_t it;
    it.kind = kind;
    it.last = last;
    it.start_x = pick_coord();
    it.start_y = pick_coord();
    it.start_z = pick_coord();
    if (flat) begin
      it.end_x = it.start_x;
      it.end_y = it.start_y;
      it.end_z = it.start_z;
    end else begin
      it.end_x = pick_coord();
      it.end_y = pick_coord();
      it.end_z = pick_coord();
    end
    return it;
  endfunction

  task automatic random_phase(int count);
    out_item_t none;
    int        sent;
    int        nseg;
    none = '0;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        // noise: anything at all, including broken queries
        send_item(make_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0), 1'b0, none);
        sent++;
      end else begin
        if ($urandom_range(7) != 0) begin
          send_item(make_item(1'b0, 1'($urandom_range(1)), 1'b0), 1'b0, none);
          sent++;
        end
        nseg = $urandom_range(1, 6);
        for (int i = 0; i < nseg; i++) begin
          send_item(make_item(1'b1, i == nseg - 1, $urandom_range(19) == 0), 1'b0, none);
          sent++;
        end
      end
    end
  endtask

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    out_ch.ready <= (hold_left == 0) && (hold_ask == hold_seen)
                    && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_dirs.size() == 0) begin
        report("unexpected result item", 1, 0);
      end else begin
        want = expected_dirs.pop_front();
        if (out_ch.data.dir_x !== want.dir_x) report("dir_x", out_ch.data.dir_x, want.dir_x);
        if (out_ch.data.dir_y !== want.dir_y) report("dir_y", out_ch.data.dir_y, want.dir_y);
        if (out_ch.data.dir_z !== want.dir_z) report("dir_z", out_ch.data.dir_z, want.dir_z);
        if (out_ch.data.degenerate !== want.degenerate)
          report("degenerate", out_ch.data.degenerate, want.degenerate);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t seg(bit kind, longint sx, longint sy, longint sz,
                                   longint ex, longint ey, longint ez, bit last);
    in_item_t it;
    it.kind = kind;
    it.start_x = CW'(sx); it.start_y = CW'(sy); it.start_z = CW'(sz);
    it.end_x = CW'(ex);   it.end_y = CW'(ey);   it.end_z = CW'(ez);
    it.last = last;
    return it;
  endfunction

  function automatic out_item_t dir(int x, int y, int z, bit degen);
    out_item_t r;
    r.dir_x = DIRW'(x);
    r.dir_y = DIRW'(y);
    r.dir_z = DIRW'(z);
    r.degenerate = degen;
    return r;
  endfunction

  initial begin
    dir_row_t  rows [$];
    out_item_t none;
    longint    lo;
    longint    hi;
    none = '0;
    lo = -64'sd2147483648;
    hi = 64'sd2147483647;
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_ask = 0;
    hold_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
    for (int k = 0; k < 3; k++) begin
      query_pt[k] = 0;
      kept_span[k] = 0;
    end
    kept_dist = '1;
    kept_valid = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;

    // segment before any query point uses the origin
    rows.push_back('{seg(1, 65536, 0, 0, 0, 0, 0, 1), 1, dir(32767, 0, 0, 0)});
    rows.push_back('{seg(1, 0, 0, 0, 65536, 0, 0, 1), 1, dir(-32767, 0, 0, 0)});
    rows.push_back('{seg(1, 0, 0, 0, 0, -327680, 0, 1), 1, dir(0, 32767, 0, 0)});
    // zero-length segment
    rows.push_back('{seg(1, 7, -9, 3, 7, -9, 3, 1), 1, dir(0, 0, 0, 1)});
    // point load with last set gives nothing
    rows.push_back('{seg(0, 65536, 65536, 65536, hi, lo, hi, 1), 0, none});
    rows.push_back('{seg(1, 0, 0, 0, 0, 0, 131072, 1), 1, dir(0, 0, -32767, 0)});
    // extremes of the coordinates
    rows.push_back('{seg(1, hi, hi, hi, lo, lo, lo, 1), 0, none});
    rows.push_back('{seg(1, lo, lo, lo, hi, hi, hi, 1), 0, none});
    rows.push_back('{seg(1, hi, lo, 0, lo, hi, -1, 1), 0, none});
    // first segment kept though its distance saturates
    rows.push_back('{seg(0, lo, lo, lo, 0, 0, 0, 0), 0, none});
    rows.push_back('{seg(1, hi, hi, hi, hi, hi, hi - 5, 0), 0, none});
    rows.push_back('{seg(1, hi, hi, hi - 9, hi, hi - 7, hi, 1), 0, none});
    // tie: earlier of two mirrored segments is kept
    rows.push_back('{seg(0, 0, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{seg(1, 65536, 65536, 0, 65536, -65536, 0, 0), 0, none});
    rows.push_back('{seg(1, -65536, -65536, 0, -65536, 65536, 0, 1), 1, dir(0, 32767, 0, 0)});
    // interior projection, then the end point nearest
    rows.push_back('{seg(0, 3 << 16, 5 << 16, -2 << 16, 0, 0, 0, 0), 0, none});
    rows.push_back('{seg(1, -10 << 16, 4 << 16, 0, 10 << 16, 6 << 16, -3 << 16, 0), 0, none});
    rows.push_back('{seg(1, 9 << 16, 9 << 16, 9 << 16, 4 << 16, 5 << 16, -1 << 16, 1), 0, none});
    // new point mid-query drops the segments so far
    rows.push_back('{seg(1, 0, 0, 0, 1, 0, 0, 0), 0, none});
    rows.push_back('{seg(0, 100, 200, 300, 0, 0, 0, 0), 0, none});
    rows.push_back('{seg(1, 100, 200, 300, 100, 200, 300, 1), 1, dir(0, 0, 0, 1)});
    rows.push_back('{seg(1, 1, 1, 1, 0, 0, 0, 1), 0, none});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want);
    drain();

    // long receiver hold-off while items keep coming
    hold_ask++;
    random_phase(ITEMS_PER_PHASE);
    drain();

    idle_pct = 79;
    random_phase(ITEMS_PER_PHASE);
    drain();

    idle_pct = 0;
    stall_pct = 79;
    random_phase(ITEMS_PER_PHASE);
    drain();

    idle_pct = 32;
    stall_pct = 32;
    random_phase(ITEMS_PER_PHASE);
    drain();

    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
